>>> rtl/running_median_two_heaps_defines.svh
// ----------------------------------------------------------------------------
// running_median_two_heaps_defines
// assertion macros for the running median rtl
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`ifndef ASSERT_OFF
`define RMH_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RMH_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RMH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> rtl/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// shared constants of the running median block
// ----------------------------------------------------------------------------
package rmh_pkg;
	localparam int CAPACITY_DEF     = 1024;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int MEDIAN_W         = 33;
	localparam int COUNT_W          = 11;
	localparam int IN_W             = 32;
endpackage

>>> rtl/rmh_if.sv
// ----------------------------------------------------------------------------
// rmh_if
// valid/ready channel carrying a payload struct
// ----------------------------------------------------------------------------
interface rmh_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rmh_heap.sv
// ----------------------------------------------------------------------------
// rmh_heap
// one binary heap in a synchronous memory, push and pop by walking levels
// ----------------------------------------------------------------------------
module rmh_heap #(
	parameter int DEPTH = 513,
	parameter int AW    = 10,
	parameter int SW    = 32,
	parameter bit IS_MAX = 1'b1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          pop,
	input  logic [SW-1:0] push_val,
	output logic          busy,
	output logic [SW-1:0] top,
	output logic [SW-1:0] popped,
	output logic [AW-1:0] size
);
	typedef enum logic [6:0] {
		H_IDLE = 7'b0000001, H_UPRD = 7'b0000010, H_UPCMP = 7'b0000100,
		H_PLAST = 7'b0001000, H_PLWAIT = 7'b0010000, H_DNRD = 7'b0100000,
		H_DNCMP = 7'b1000000
	} hstate_t;

	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] rd_a_q, rd_b_q, val_q, top_q;
	logic [AW-1:0] ra, rb, wa, idx_q, size_q;
	logic [SW-1:0] wd;
	logic          we, l_ok_q, r_ok_q;
	hstate_t       st_q;

	function automatic logic outranks(input logic [SW-1:0] a, input logic [SW-1:0] b);
		outranks = IS_MAX ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	logic [AW-1:0] par, lch, rch;
	logic          l_ok, r_ok, take_r, swap_dn, up_swap;
	logic [SW-1:0] best_v;
	assign par  = (idx_q - AW'(1)) >> 1;
	assign lch  = AW'({idx_q, 1'b1});
	assign rch  = lch + AW'(1);
	assign l_ok = ({1'b0, idx_q, 1'b1} < {2'b0, size_q});
	assign r_ok = ({1'b0, idx_q, 1'b1} + (AW+2)'(1) < {2'b0, size_q});
	assign take_r  = r_ok_q && outranks(rd_b_q, rd_a_q);
	assign best_v  = take_r ? rd_b_q : rd_a_q;
	assign swap_dn = l_ok_q && outranks(best_v, val_q);
	assign up_swap = (idx_q != '0) && outranks(val_q, rd_a_q);

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	always_comb begin
		we = 1'b0; wa = idx_q; wd = val_q; ra = par; rb = rch;
		case (st_q)
			H_IDLE: begin
				if (push) begin
					we = 1'b1; wa = size_q; wd = push_val;
				end
				ra = size_q - AW'(1);
			end
			H_UPRD: ra = par;
			H_UPCMP: begin
				we = 1'b1; wa = idx_q;
				wd = up_swap ? rd_a_q : val_q;
			end
			H_PLAST: ra = size_q;
			H_PLWAIT: begin ra = lch; rb = rch; end
			H_DNRD: begin ra = lch; rb = rch; end
			H_DNCMP: begin
				we = 1'b1; wa = idx_q;
				wd = swap_dn ? best_v : val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= H_IDLE;
			size_q <= '0;
			top_q  <= '0;
			idx_q  <= '0;
			val_q  <= '0;
			popped <= '0;
			l_ok_q <= 1'b0;
			r_ok_q <= 1'b0;
		end else begin
			case (st_q)
				H_IDLE: begin
					if (push) begin
						idx_q  <= size_q;
						val_q  <= push_val;
						size_q <= size_q + AW'(1);
						if (size_q == '0) top_q <= push_val;
						else st_q <= H_UPRD;
					end else if (pop) begin
						popped <= top_q;
						size_q <= size_q - AW'(1);
						idx_q  <= '0;
						st_q   <= H_PLAST;
					end
				end
				H_UPRD: st_q <= H_UPCMP;
				H_UPCMP: begin
					if (up_swap) begin
						if (par == '0) top_q <= val_q;
						idx_q <= par;
						st_q  <= H_UPRD;
					end else begin
						st_q <= H_IDLE;
					end
				end
				H_PLAST: st_q <= H_PLWAIT;
				H_PLWAIT: begin
					val_q <= rd_a_q;
					if (size_q == '0) st_q <= H_IDLE;
					else begin
						top_q <= rd_a_q;
						st_q  <= H_DNRD;
					end
				end
				H_DNRD: begin
					l_ok_q <= l_ok;
					r_ok_q <= r_ok;
					st_q   <= H_DNCMP;
				end
				H_DNCMP: begin
					if (swap_dn) begin
						if (idx_q == '0) top_q <= best_v;
						idx_q <= take_r ? rch : lch;
						st_q  <= H_DNRD;
					end else begin
						if (idx_q == '0) top_q <= val_q;
						st_q <= H_IDLE;
					end
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end

	assign busy = (st_q != H_IDLE);
	assign top  = top_q;
	assign size = size_q;
endmodule

>>> rtl/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// running median of a signed stream using a max-heap and a min-heap in memory
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   sample
// out_ch    out  median_doubled, held_count, dropped
// an insert walks a heap up through its read and compare states for each level it climbs; a
// rebalance adds a pop (a read of the last element, then a read and a compare for each level)
// and a push into the other half; a new sample is accepted only once the last one is done
// and its result taken, and a dropped sample goes straight to the result without the heaps
// reset clears sizes and median; heap memories are not cleared
// a stalled result holds in the output register; the next sample waits for it
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_defines.svh"

module running_median_two_heaps #(
	parameter int CAPACITY     = rmh_pkg::CAPACITY_DEF,
	parameter int SAMPLE_WIDTH = rmh_pkg::SAMPLE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	rmh_if.sink   in_ch,
	rmh_if.source out_ch
);
	localparam int DEPTH = CAPACITY / 2 + 1;
	localparam int AW    = $clog2(DEPTH + 1);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int SW    = SAMPLE_WIDTH;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_INS = 5'b00010, S_BAL = 5'b00100,
		S_MOVE = 5'b01000, S_OUT = 5'b10000
	} state_t;

	state_t        st_q;
	logic [SW:0]   med_q;
	logic          out_v_q, drop_q, mv_lo_q;
	logic [SW-1:0] smp;
	logic          go_lo, full;
	logic          lo_push, lo_pop, hi_push, hi_pop, lo_busy, hi_busy;
	logic [SW-1:0] lo_top, hi_top, lo_pv, hi_pv, lo_in, hi_in;
	logic [AW-1:0] lo_sz, hi_sz;
	logic [CW-1:0] held;
	logic          balanced;

	assign smp  = in_ch.data.sample[SW-1:0];
	assign held = CW'(lo_sz) + CW'(hi_sz);
	assign full = (held >= CW'(CAPACITY));
	assign go_lo = (held == '0) ||
		($signed({smp[SW-1], smp, 1'b0}) <= $signed({med_q[SW], med_q}));
	assign balanced = (lo_sz <= hi_sz + AW'(1)) && (hi_sz <= lo_sz + AW'(1));

	rmh_heap #(.DEPTH(DEPTH), .AW(AW), .SW(SW), .IS_MAX(1'b1)) u_lo (
		.clk, .arst_n, .push(lo_push), .pop(lo_pop), .push_val(lo_in),
		.busy(lo_busy), .top(lo_top), .popped(lo_pv), .size(lo_sz));
	rmh_heap #(.DEPTH(DEPTH), .AW(AW), .SW(SW), .IS_MAX(1'b0)) u_hi (
		.clk, .arst_n, .push(hi_push), .pop(hi_pop), .push_val(hi_in),
		.busy(hi_busy), .top(hi_top), .popped(hi_pv), .size(hi_sz));

	logic accept;
	assign in_ch.ready = (st_q == S_IDLE) && !out_v_q;
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		lo_push = 1'b0; hi_push = 1'b0; lo_pop = 1'b0; hi_pop = 1'b0;
		lo_in = smp; hi_in = smp;
		case (st_q)
			S_IDLE: if (accept && !full) begin
				lo_push = go_lo; hi_push = !go_lo;
			end
			S_BAL: if (!lo_busy && !hi_busy) begin
				if (hi_sz > lo_sz + AW'(1)) hi_pop = 1'b1;
				else if (lo_sz > hi_sz + AW'(1)) lo_pop = 1'b1;
			end
			S_MOVE: if (!lo_busy && !hi_busy) begin
				lo_push = mv_lo_q; hi_push = !mv_lo_q;
				lo_in = hi_pv; hi_in = lo_pv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; med_q <= '0; out_v_q <= 1'b0; drop_q <= 1'b0;
			mv_lo_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: if (accept) begin
					drop_q <= full;
					if (full) out_v_q <= 1'b1;
					else st_q <= S_BAL;
				end
				S_BAL: if (!lo_busy && !hi_busy) begin
					if (hi_pop) begin mv_lo_q <= 1'b1; st_q <= S_MOVE; end
					else if (lo_pop) begin mv_lo_q <= 1'b0; st_q <= S_MOVE; end
					else st_q <= S_OUT;
				end
				S_MOVE: if (!lo_busy && !hi_busy) st_q <= S_BAL;
				S_OUT: begin
					if (lo_sz > hi_sz) med_q <= {lo_top, 1'b0};
					else if (hi_sz > lo_sz) med_q <= {hi_top, 1'b0};
					else med_q <= {lo_top[SW-1], lo_top} + {hi_top[SW-1], hi_top};
					out_v_q <= 1'b1;
					st_q    <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data.median_doubled = rmh_pkg::MEDIAN_W'($signed(med_q));
	assign out_ch.data.held_count     = rmh_pkg::COUNT_W'(held);
	assign out_ch.data.dropped        = drop_q;

	`RMH_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, !(accept && (lo_busy || hi_busy)), "accept busy")
	`RMH_ASSERT_IMPL(a_bal_out, clk, arst_n, (st_q == S_OUT) |-> balanced, "heaps unbalanced")
	`RMH_ASSERT_NEXT(a_drop_keeps, clk, arst_n, accept && full, $stable(held), "drop changed count")
endmodule

>>> verif/rmh_test_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmh_test_pkg
// transaction layouts of the running median channels as seen by the bench
// ----------------------------------------------------------------------------
package rmh_test_pkg;
	typedef struct packed {
		logic signed [rmh_pkg::IN_W-1:0] sample;
	} sample_t;

	typedef struct packed {
		logic signed [rmh_pkg::MEDIAN_W-1:0] median_doubled;
		logic [rmh_pkg::COUNT_W-1:0]         held_count;
		logic                                dropped;
	} median_t;
endpackage

>>> verif/running_median_two_heaps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_checker
// watches both channels, keeps its own sorted copy of both halves of the
// sample set, and compares every result transaction with the expected median, count and drop flag
// ----------------------------------------------------------------------------
module running_median_two_heaps_checker (
	input logic clk,
	input logic arst_n,
	rmh_if      in_ch,
	rmh_if      out_ch,
	output int  fails,
	output int  pending,
	output int  drops_seen,
	output int  results_seen
);
	localparam int HELD_MAX = rmh_pkg::CAPACITY_DEF;

	longint                medians_unused;
	longint                lower_half[$];
	longint                upper_half[$];
	longint                median2;
	rmh_test_pkg::median_t medians_due[$];

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	function automatic void insert_sorted(ref longint q[$], input longint v);
		int i;
		i = 0;
		while (i < q.size() && q[i] <= v)
			i++;
		q.insert(i, v);
	endfunction

	function automatic rmh_test_pkg::median_t next_median(
		input logic signed [rmh_pkg::IN_W-1:0] s);
		rmh_test_pkg::median_t r;
		longint                v;
		longint                moved;
		int                    held;
		v    = s;
		held = lower_half.size() + upper_half.size();
		r.dropped = 1'b0;
		if (held >= HELD_MAX) begin
			r.dropped = 1'b1;
		end else begin
			if (held == 0 || 2 * v <= median2)
				insert_sorted(lower_half, v);
			else
				insert_sorted(upper_half, v);
			while (upper_half.size() > lower_half.size() + 1)
				insert_sorted(lower_half, upper_half.pop_front());
			while (lower_half.size() > upper_half.size() + 1) begin
				moved = lower_half[$];
				lower_half.delete(lower_half.size() - 1);
				insert_sorted(upper_half, moved);
			end
			if (lower_half.size() > upper_half.size())
				median2 = 2 * lower_half[$];
			else if (upper_half.size() > lower_half.size())
				median2 = 2 * upper_half[0];
			else
				median2 = lower_half[$] + upper_half[0];
			held = lower_half.size() + upper_half.size();
		end
		r.median_doubled = median2[rmh_pkg::MEDIAN_W-1:0];
		r.held_count     = held[rmh_pkg::COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		rmh_test_pkg::median_t got;
		rmh_test_pkg::median_t want;
		if (!arst_n) begin
			median2 = 0;
			lower_half.delete();
			upper_half.delete();
			medians_due.delete();
			pending <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				medians_due.insert(medians_due.size(), next_median(in_ch.data.sample));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				results_seen++;
				if (got.dropped)
					drops_seen++;
				if (medians_due.size() == 0) begin
					report("result without a sample", 1, 0);
				end else begin
					want = medians_due.pop_front();
					if (got.median_doubled !== want.median_doubled)
						report("median_doubled", got.median_doubled, want.median_doubled);
					if (got.held_count !== want.held_count)
						report("held_count", got.held_count, want.held_count);
					if (got.dropped !== want.dropped)
						report("dropped", got.dropped, want.dropped);
				end
			end
			pending <= medians_due.size();
		end
	end
endmodule

>>> verif/running_median_two_heaps_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_test
// drives a directed then random sample stream past the capacity of the block,
// with random idling on both sides, and reports the checker's verdict
// ----------------------------------------------------------------------------
module running_median_two_heaps_test;
	localparam int RANDOM_ITEMS = 1580;
	localparam int CALM_ITEMS   = 250;
	localparam int LONG_HOLD    = 300;
	localparam int WATCHDOG     = 5000;

	logic clk;
	logic arst_n;
	logic calm;
	logic long_hold;
	int   fails;
	int   pending;
	int   drops_seen;
	int   results_seen;
	int   quiet;

	rmh_if #(.payload_t(rmh_test_pkg::sample_t)) in_ch ();
	rmh_if #(.payload_t(rmh_test_pkg::median_t)) out_ch ();

	running_median_two_heaps i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	running_median_two_heaps_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.fails        (fails),
		.pending      (pending),
		.drops_seen   (drops_seen),
		.results_seen (results_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	// receiver side
	initial begin
		int n;
		bit hold_done;
		out_ch.ready = 1'b0;
		hold_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
				out_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 9);
				out_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(input logic signed [rmh_pkg::IN_W-1:0] s);
		rmh_test_pkg::sample_t t;
		int                    n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 9);
			@(negedge clk) in_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		t.sample = s;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data  <= t;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic logic signed [rmh_pkg::IN_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000 + $urandom_range(0, 3);
			1: return 32'sh7fff_ffff - $urandom_range(0, 3);
			2, 3: return $signed($urandom_range(0, 40)) - 20;
			4: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		calm        = 1'b0;
		long_hold   = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		@(posedge arst_n);
		// first sample, extremes, ties with the median, equal pairs
		send(32'sd5);
		send(32'sd5);
		send(32'sd4);
		send(32'sd6);
		send(32'sh8000_0000);
		send(32'sh7fff_ffff);
		send(32'sh7fff_ffff);
		send(32'sh8000_0000);
		send(32'sh7fff_ffff);
		send(32'sh7fff_ffff);
		send(32'sh7fff_ffff);
		send(32'sd0);
		send(-32'sd1);
		send(32'sd1);
		send(32'sh5555_5555);
		send(32'shaaaa_aaaa);
		send(32'sd5);
		send(32'sd5);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100) begin
				long_hold = 1'b1;
			end
			if (i == 600) begin
				@(negedge clk) in_ch.valid <= 1'b0;
				wait (pending == 0);
			end
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send(random_sample());
		end
		@(negedge clk) in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("%0d median results checked, %0d of them refused with a full store",
			results_seen, drops_seen);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

>>> running_median_two_heaps.f
+incdir+rtl
rtl/rmh_pkg.sv
rtl/rmh_if.sv
rtl/rmh_heap.sv
rtl/running_median_two_heaps.sv
verif/rmh_test_pkg.sv
verif/running_median_two_heaps_checker.sv
verif/running_median_two_heaps_test.sv
